### sv/napt_pkg.sv
// shared types, codes and constants of the napt translation engine
`timescale 1ns / 1ps
package napt_pkg;

    // default table depths
    localparam int PORT_TABLE_DEPTH_DEF = 1024;
    localparam int ICMP_TABLE_DEPTH_DEF = 1024;

    // number of checksum cells in the chain
    localparam int NUM_CELLS = 9;

    localparam logic [15:0] MASK16 = 16'hffff;
    localparam logic [15:0] GLOBAL_PORT_BASE_RESET = 16'd20000;

    // protocol codes
    localparam logic [1:0] PROTO_TCP  = 2'd0;
    localparam logic [1:0] PROTO_UDP  = 2'd1;
    localparam logic [1:0] PROTO_ICMP = 2'd2;
    localparam logic [1:0] PROTO_NONE = 2'd3;

    // icmp echo types
    localparam logic [7:0] ICMP_ECHO_REQUEST = 8'd8;
    localparam logic [7:0] ICMP_ECHO_REPLY   = 8'd0;

    // status codes
    localparam logic [1:0] STATUS_OK         = 2'd0;
    localparam logic [1:0] STATUS_NOT_ECHO   = 2'd1;
    localparam logic [1:0] STATUS_NO_MAPPING = 2'd2;
    localparam logic [1:0] STATUS_TABLE_FULL = 2'd3;

    // register indexes
    localparam logic REG_OUTSIDE_ADDR     = 1'b0;
    localparam logic REG_GLOBAL_PORT_BASE = 1'b1;

    typedef struct packed {
        logic        direction;
        logic [1:0]  protocol;
        logic [7:0]  icmp_type;
        logic [31:0] src_ip;
        logic [31:0] dst_addr;
        logic [15:0] src_ident;
        logic [15:0] dst_port;
        logic [15:0] l4_checksum;
        logic [63:0] ip_head_front;
        logic [15:0] ip_ttl_protocol;
    } in_word_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] new_src_addr;
        logic [31:0] new_dst_addr;
        logic [15:0] new_src_port;
        logic [15:0] new_dst_port;
        logic [15:0] new_l4_checksum;
        logic [15:0] new_ip_checksum;
    } out_word_t;

    // one translation table entry
    typedef struct packed {
        logic        valid;
        logic [47:0] local_key;
        logic [31:0] pub_addr;
    } entry_t;

    // running sums of the two checksum lanes
    typedef struct packed {
        logic [15:0] l4;
        logic [15:0] ip;
    } csum_pair_t;

endpackage

### sv/napt_ram.sv
// generic single-write, single-read ram with registered read data
`timescale 1ns / 1ps
module napt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port and registered read port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

### sv/napt_csum_cell.sv
// one cell of the ones-complement adder chain, two lanes
`timescale 1ns / 1ps
module napt_csum_cell
    import napt_pkg::*;
(
    input  logic       clk,
    input  csum_pair_t acc_in,
    input  csum_pair_t word,
    output csum_pair_t acc_out
);

    logic [16:0] l4_sum;
    logic [16:0] ip_sum;

    // add with end-around carry
    always_comb
    begin
        l4_sum = {1'b0, acc_in.l4} + {1'b0, word.l4};
        ip_sum = {1'b0, acc_in.ip} + {1'b0, word.ip};
    end

    always_ff @(posedge clk)
    begin
        acc_out.l4 <= l4_sum[15:0] + {15'd0, l4_sum[16]};
        acc_out.ip <= ip_sum[15:0] + {15'd0, ip_sum[16]};
    end

endmodule

### sv/napt_translate_engine_core.sv
// top level of the napt translation engine: tables, sequencer, checksum chain
//
// Input words arrive on in_valid/in_word and are taken when in_stall is low;
// one result word per input leaves on out_valid/out_word and is held until
// out_stall is low. The outside address (0x0) and global_port_base (0x4)
// are written through the apb-style port, pready is always high.
// After reset the three translation tables are cleared, one entry a cycle,
// all 2*PORT_TABLE_DEPTH+ICMP_TABLE_DEPTH entries, with in_stall high.
// One word at a time is worked on. An outgoing word scans its table entry
// by entry (ram read, then compare) and, when no entry matches, writes a
// new mapping into a free slot. Incoming words do a direct lookup (ram
// read, then compare), unknown or non-echo words none. Then the checksums
// pass a chain of 9 adder cells: a prep step, the chain and an output step.
// The result waits in the output register while out_stall is high; the
// next input word is still taken and worked until its result is ready.
`timescale 1ns / 1ps
module napt_translate_engine_core
    import napt_pkg::*;
#(
    parameter int PORT_TABLE_DEPTH = PORT_TABLE_DEPTH_DEF,
    parameter int ICMP_TABLE_DEPTH = ICMP_TABLE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_word_t    in_word,
    output logic        out_valid,
    input  logic        out_stall,
    output out_word_t   out_word,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int TOTAL_DEPTH = 2 * PORT_TABLE_DEPTH + ICMP_TABLE_DEPTH;
    localparam int ADDR_W      = $clog2(TOTAL_DEPTH);
    localparam int CNT_W       = 17;
    localparam int ENTRY_W     = $bits(entry_t);

    // sequencer states
    localparam logic [3:0] S_CLEAR    = 4'd0;
    localparam logic [3:0] S_IDLE     = 4'd1;
    localparam logic [3:0] S_LOOK_RD  = 4'd2;
    localparam logic [3:0] S_LOOK_CHK = 4'd3;
    localparam logic [3:0] S_SCAN_RD  = 4'd4;
    localparam logic [3:0] S_SCAN_CHK = 4'd5;
    localparam logic [3:0] S_WRITE    = 4'd6;
    localparam logic [3:0] S_PREP     = 4'd7;
    localparam logic [3:0] S_RUN      = 4'd8;
    localparam logic [3:0] S_DONE     = 4'd9;

    logic [3:0]        state_reg, state_next;
    logic [ADDR_W-1:0] clr_reg, clr_next;
    logic [CNT_W-1:0]  scan_reg, scan_next;
    logic              free_found_reg, free_found_next;
    logic [15:0]       free_idx_reg, free_idx_next;
    logic [15:0]       idx_reg, idx_next;
    logic              found_reg, found_next;
    logic [1:0]        status_reg, status_next;
    logic [3:0]        run_reg, run_next;
    in_word_t          item_reg, item_next;
    entry_t            ent_reg, ent_next;
    logic [31:0]       outside_reg;
    logic [15:0]       base_reg;
    logic              out_valid_reg, out_valid_next;
    out_word_t         out_word_reg, out_word_next;

    // translated header fields and chain words
    logic [31:0]       nsa_reg, nsa_next;
    logic [31:0]       nda_reg, nda_next;
    logic [15:0]       nsp_reg, nsp_next;
    logic [15:0]       ndp_reg, ndp_next;
    csum_pair_t        w_reg  [NUM_CELLS];
    csum_pair_t        w_next [NUM_CELLS];
    csum_pair_t        chain  [NUM_CELLS];

    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    entry_t            ram_wdata;
    logic [ADDR_W-1:0] ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata_bits;
    entry_t            ram_rdata;

    logic [ADDR_W-1:0] tbase;
    logic [CNT_W-1:0]  depth;
    logic [47:0]       item_key;
    logic [15:0]       in_idx;
    logic [CNT_W-1:0]  in_depth;
    logic              in_pass;
    logic              accept;
    logic              cfg_write;

    // configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite;
    assign prdata    = (paddr[2] == REG_GLOBAL_PORT_BASE) ? {16'd0, base_reg} : outside_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            outside_reg <= 32'd0;
            base_reg    <= GLOBAL_PORT_BASE_RESET;
        end
        else if (cfg_write)
        begin
            if (paddr[2] == REG_OUTSIDE_ADDR)
            begin
                outside_reg <= pwdata;
            end
            else
            begin
                base_reg <= pwdata[15:0];
            end
        end
    end

    // table base and depth of the current word's protocol
    always_comb
    begin
        case (item_reg.protocol)
            PROTO_TCP:
            begin
                tbase = '0;
                depth = CNT_W'(PORT_TABLE_DEPTH);
            end
            PROTO_UDP:
            begin
                tbase = ADDR_W'(PORT_TABLE_DEPTH);
                depth = CNT_W'(PORT_TABLE_DEPTH);
            end
            default:
            begin
                tbase = ADDR_W'(2 * PORT_TABLE_DEPTH);
                depth = CNT_W'(ICMP_TABLE_DEPTH);
            end
        endcase
    end

    assign item_key = {item_reg.src_ip, item_reg.src_ident};

    // classification of the arriving word
    always_comb
    begin
        in_pass = (in_word.protocol == PROTO_NONE)
            || (in_word.protocol == PROTO_ICMP && in_word.icmp_type != ICMP_ECHO_REQUEST
                && in_word.icmp_type != ICMP_ECHO_REPLY);
        if (in_word.protocol == PROTO_ICMP)
        begin
            in_idx   = in_word.src_ident;
            in_depth = CNT_W'(ICMP_TABLE_DEPTH);
        end
        else
        begin
            in_idx   = in_word.dst_port - base_reg;
            in_depth = CNT_W'(PORT_TABLE_DEPTH);
        end
    end

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;

    // table memory
    always_comb
    begin
        ram_we    = (state_reg == S_CLEAR) || (state_reg == S_WRITE);
        ram_waddr = (state_reg == S_CLEAR) ? clr_reg : tbase + ADDR_W'(idx_reg);
        ram_wdata = (state_reg == S_CLEAR) ? '0 : {1'b1, item_key, outside_reg};
        ram_raddr = (state_reg == S_SCAN_RD) ? tbase + ADDR_W'(scan_reg[15:0])
                                             : tbase + ADDR_W'(idx_reg);
    end

    napt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (TOTAL_DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata_bits)
    );

    assign ram_rdata = entry_t'(ram_rdata_bits);

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        scan_next       = scan_reg;
        free_found_next = free_found_reg;
        free_idx_next   = free_idx_reg;
        idx_next        = idx_reg;
        found_next      = found_reg;
        status_next     = status_reg;
        run_next        = run_reg;
        item_next       = item_reg;
        ent_next        = ent_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_word_next   = out_word_reg;
        case (state_reg)
            S_CLEAR:
            begin
                clr_next = clr_reg + 1'b1;
                if (clr_reg == ADDR_W'(TOTAL_DEPTH - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    item_next       = in_word;
                    found_next      = 1'b0;
                    status_next     = STATUS_OK;
                    scan_next       = '0;
                    free_found_next = 1'b0;
                    idx_next        = in_idx;
                    if (in_pass)
                    begin
                        status_next = STATUS_NOT_ECHO;
                        state_next  = S_PREP;
                    end
                    else if (in_word.direction)
                    begin
                        if ({1'b0, in_idx} < in_depth)
                        begin
                            state_next = S_LOOK_RD;
                        end
                        else
                        begin
                            status_next = STATUS_NO_MAPPING;
                            state_next  = S_PREP;
                        end
                    end
                    else
                    begin
                        state_next = S_SCAN_RD;
                    end
                end
            end
            S_LOOK_RD:
            begin
                state_next = S_LOOK_CHK;
            end
            S_LOOK_CHK:
            begin
                ent_next = ram_rdata;
                if (ram_rdata.valid && ram_rdata.pub_addr == item_reg.dst_addr)
                begin
                    found_next = 1'b1;
                end
                else
                begin
                    status_next = STATUS_NO_MAPPING;
                end
                state_next = S_PREP;
            end
            S_SCAN_RD:
            begin
                state_next = S_SCAN_CHK;
            end
            S_SCAN_CHK:
            begin
                if (ram_rdata.valid && ram_rdata.local_key == item_key)
                begin
                    found_next = 1'b1;
                    idx_next   = scan_reg[15:0];
                    ent_next   = ram_rdata;
                    state_next = S_PREP;
                end
                else
                begin
                    if (!ram_rdata.valid && !free_found_reg)
                    begin
                        free_found_next = 1'b1;
                        free_idx_next   = scan_reg[15:0];
                    end
                    if (scan_reg == depth - 1'b1)
                    begin
                        if (free_found_reg)
                        begin
                            idx_next   = free_idx_reg;
                            state_next = S_WRITE;
                        end
                        else if (!ram_rdata.valid)
                        begin
                            idx_next   = scan_reg[15:0];
                            state_next = S_WRITE;
                        end
                        else
                        begin
                            status_next = STATUS_TABLE_FULL;
                            state_next  = S_PREP;
                        end
                    end
                    else
                    begin
                        scan_next  = scan_reg + 1'b1;
                        state_next = S_SCAN_RD;
                    end
                end
            end
            S_WRITE:
            begin
                ent_next   = {1'b1, item_key, outside_reg};
                found_next = 1'b1;
                state_next = S_PREP;
            end
            S_PREP:
            begin
                run_next   = '0;
                state_next = S_RUN;
            end
            S_RUN:
            begin
                run_next = run_reg + 1'b1;
                if (run_reg == 4'(NUM_CELLS - 1))
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next               = 1'b1;
                    out_word_next.status         = status_reg;
                    out_word_next.new_src_addr   = nsa_reg;
                    out_word_next.new_dst_addr   = nda_reg;
                    out_word_next.new_src_port   = nsp_reg;
                    out_word_next.new_dst_port   = ndp_reg;
                    out_word_next.new_ip_checksum = ~chain[NUM_CELLS-1].ip;
                    if (!found_reg)
                    begin
                        out_word_next.new_l4_checksum = item_reg.l4_checksum;
                    end
                    else if (item_reg.protocol == PROTO_UDP && item_reg.l4_checksum == 16'd0)
                    begin
                        out_word_next.new_l4_checksum = 16'd0;
                    end
                    else if (item_reg.protocol == PROTO_UDP && chain[NUM_CELLS-1].l4 == MASK16)
                    begin
                        out_word_next.new_l4_checksum = MASK16;
                    end
                    else
                    begin
                        out_word_next.new_l4_checksum = ~chain[NUM_CELLS-1].l4;
                    end
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // translated fields and checksum words
    always_comb
    begin
        logic [15:0] gport;
        logic [31:0] laddr;
        logic [15:0] lport;
        logic [15:0] old0, old1, old2, new0, new1, new2;
        gport = (item_reg.protocol == PROTO_ICMP) ? idx_reg : base_reg + idx_reg;
        laddr = ent_reg.local_key[47:16];
        lport = ent_reg.local_key[15:0];
        nsa_next = item_reg.src_ip;
        nda_next = item_reg.dst_addr;
        nsp_next = item_reg.src_ident;
        ndp_next = item_reg.dst_port;
        old1 = MASK16;
        old2 = MASK16;
        new1 = 16'd0;
        new2 = 16'd0;
        if (item_reg.protocol == PROTO_ICMP)
        begin
            old0 = item_reg.src_ident;
            new0 = item_reg.direction ? lport : gport;
            if (found_reg)
            begin
                nsp_next = new0;
                if (item_reg.direction)
                begin
                    nda_next = laddr;
                end
                else
                begin
                    nsa_next = ent_reg.pub_addr;
                end
            end
        end
        else if (!item_reg.direction)
        begin
            old0 = item_reg.src_ip[31:16];
            old1 = item_reg.src_ip[15:0];
            old2 = item_reg.src_ident;
            new0 = ent_reg.pub_addr[31:16];
            new1 = ent_reg.pub_addr[15:0];
            new2 = gport;
            if (found_reg)
            begin
                nsa_next = ent_reg.pub_addr;
                nsp_next = gport;
            end
        end
        else
        begin
            old0 = item_reg.dst_addr[31:16];
            old1 = item_reg.dst_addr[15:0];
            old2 = item_reg.dst_port;
            new0 = laddr[31:16];
            new1 = laddr[15:0];
            new2 = lport;
            if (found_reg)
            begin
                nda_next = laddr;
                ndp_next = lport;
            end
        end
        w_next[0] = '{l4: ~item_reg.l4_checksum, ip: item_reg.ip_head_front[63:48]};
        w_next[1] = '{l4: ~old0, ip: item_reg.ip_head_front[47:32]};
        w_next[2] = '{l4: new0,  ip: item_reg.ip_head_front[31:16]};
        w_next[3] = '{l4: ~old1, ip: item_reg.ip_head_front[15:0]};
        w_next[4] = '{l4: new1,  ip: item_reg.ip_ttl_protocol};
        w_next[5] = '{l4: ~old2, ip: nsa_next[31:16]};
        w_next[6] = '{l4: new2,  ip: nsa_next[15:0]};
        w_next[7] = '{l4: 16'd0, ip: nda_next[31:16]};
        w_next[8] = '{l4: 16'd0, ip: nda_next[15:0]};
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_CLEAR;
            clr_reg        <= '0;
            scan_reg       <= '0;
            free_found_reg <= 1'b0;
            run_reg        <= '0;
            found_reg      <= 1'b0;
            status_reg     <= STATUS_OK;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_reg        <= clr_next;
            scan_reg       <= scan_next;
            free_found_reg <= free_found_next;
            run_reg        <= run_next;
            found_reg      <= found_next;
            status_reg     <= status_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        free_idx_reg <= free_idx_next;
        idx_reg      <= idx_next;
        item_reg     <= item_next;
        ent_reg      <= ent_next;
        out_word_reg <= out_word_next;
        if (state_reg == S_PREP)
        begin
            nsa_reg <= nsa_next;
            nda_reg <= nda_next;
            nsp_reg <= nsp_next;
            ndp_reg <= ndp_next;
            for (int k = 0; k < NUM_CELLS; k++)
            begin
                w_reg[k] <= w_next[k];
            end
        end
    end

    // chain of checksum cells
    for (genvar k = 0; k < NUM_CELLS; k++)
    begin : g_cell
        if (k == 0)
        begin : g_first
            napt_csum_cell u_cell (
                .clk     (clk),
                .acc_in  ('0),
                .word    (w_reg[k]),
                .acc_out (chain[k])
            );
        end
        else
        begin : g_rest
            napt_csum_cell u_cell (
                .clk     (clk),
                .acc_in  (chain[k-1]),
                .word    (w_reg[k]),
                .acc_out (chain[k])
            );
        end
    end

    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    // table writes happen only while clearing or making a new mapping
    assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == S_CLEAR || state_reg == S_WRITE))
        else $error("table written outside clear or mapping");

    // the scan never runs past the table
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN_RD || state_reg == S_SCAN_CHK) |-> (scan_reg < depth))
        else $error("scan index beyond table depth");

    // an accepted word leaves the idle state
    assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg != S_IDLE))
        else $error("accepted word not taken into work");

    // a new result is loaded only when the output slot is free
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE && out_valid_reg && out_stall) |=> (state_reg == S_DONE))
        else $error("result overwrote a pending word");

endmodule

### bench/tb_top.sv
// testbench for the napt translation engine: random and directed packets checked by a predictor
`timescale 1ns / 1ps
module tb_top;
    import napt_pkg::*;

    localparam int PDEPTH = PORT_TABLE_DEPTH_DEF;
    localparam int IDEPTH = ICMP_TABLE_DEPTH_DEF;
    localparam int TDEPTH = 2 * PDEPTH + IDEPTH;
    localparam int QUIET_LIMIT = 40000;

    // translation state mirrored by the scoreboard
    class napt_scoreboard;
        logic [31:0] wan_addr;
        logic [15:0] port_base;
        bit          map_valid[TDEPTH];
        logic [47:0] map_key[TDEPTH];
        logic [31:0] map_gaddr[TDEPTH];
        out_word_t   pending[$];
        int          mismatches;
        int          checked;

        function void clear();
            wan_addr = '0;
            port_base = GLOBAL_PORT_BASE_RESET;
            foreach (map_valid[i]) map_valid[i] = 0;
            pending.delete();
        endfunction

        function logic [15:0] fold(logic [31:0] s);
            while (s[31:16] != 0) s = {16'd0, s[15:0]} + {16'd0, s[31:16]};
            return s[15:0];
        endfunction

        // one's complement header checksum over the 20-byte header
        function logic [15:0] header_sum(in_word_t w, logic [31:0] sa, logic [31:0] da);
            logic [31:0] s;
            s = w.ip_head_front[63:48] + w.ip_head_front[47:32] + w.ip_head_front[31:16]
                + w.ip_head_front[15:0] + w.ip_ttl_protocol + sa[31:16] + sa[15:0]
                + da[31:16] + da[15:0];
            return ~fold(s);
        endfunction

        // incremental transport checksum update
        function logic [15:0] adjust(logic [15:0] hc, logic [15:0] o[3], logic [15:0] n[3],
                                     int cnt);
            logic [31:0] s;
            s = {16'd0, ~hc};
            for (int i = 0; i < cnt; i++) begin
                s = s + {16'd0, ~o[i]} + {16'd0, n[i]};
                s = {16'd0, fold(s)};
            end
            return ~s[15:0];
        endfunction

        // work out the translation of an accepted word
        function void note_packet(in_word_t w);
            out_word_t r;
            int tbase, depth, idx, e;
            bit hit;
            logic [15:0] gport, lport, port;
            logic [31:0] gaddr, laddr;
            logic [15:0] o[3], n[3];
            int cnt;
            r.status = STATUS_OK;
            r.new_src_addr = w.src_ip;
            r.new_dst_addr = w.dst_addr;
            r.new_src_port = w.src_ident;
            r.new_dst_port = w.dst_port;
            r.new_l4_checksum = w.l4_checksum;
            hit = 0;
            idx = 0;
            if (w.protocol == PROTO_NONE || (w.protocol == PROTO_ICMP
                && w.icmp_type != ICMP_ECHO_REQUEST && w.icmp_type != ICMP_ECHO_REPLY)) begin
                r.status = STATUS_NOT_ECHO;
            end else begin
                tbase = (w.protocol == PROTO_TCP) ? 0 : (w.protocol == PROTO_UDP) ? PDEPTH
                        : 2 * PDEPTH;
                depth = (w.protocol == PROTO_ICMP) ? IDEPTH : PDEPTH;
                if (w.direction) begin
                    port = (w.protocol == PROTO_ICMP) ? w.src_ident : w.dst_port - port_base;
                    idx = port;
                    if (idx < depth && map_valid[tbase + idx]
                        && map_gaddr[tbase + idx] == w.dst_addr) hit = 1;
                    else r.status = STATUS_NO_MAPPING;
                end else begin
                    for (int i = 0; i < depth && !hit; i++)
                        if (map_valid[tbase + i] && map_key[tbase + i] == {w.src_ip, w.src_ident})
                        begin
                            idx = i;
                            hit = 1;
                        end
                    for (int i = 0; i < depth && !hit; i++)
                        if (!map_valid[tbase + i]) begin
                            idx = i;
                            hit = 1;
                            map_valid[tbase + i] = 1;
                            map_key[tbase + i] = {w.src_ip, w.src_ident};
                            map_gaddr[tbase + i] = wan_addr;
                        end
                    if (!hit) r.status = STATUS_TABLE_FULL;
                end
                if (hit) begin
                    e = tbase + idx;
                    gport = (w.protocol == PROTO_ICMP) ? idx[15:0] : port_base + idx[15:0];
                    gaddr = map_gaddr[e];
                    laddr = map_key[e][47:16];
                    lport = map_key[e][15:0];
                    if (w.protocol == PROTO_ICMP) begin
                        o[0] = w.src_ident;
                        n[0] = w.direction ? lport : gport;
                        r.new_src_port = n[0];
                        cnt = 1;
                    end else if (!w.direction) begin
                        o = '{w.src_ip[31:16], w.src_ip[15:0], w.src_ident};
                        n = '{gaddr[31:16], gaddr[15:0], gport};
                        r.new_src_addr = gaddr;
                        r.new_src_port = gport;
                        cnt = 3;
                    end else begin
                        o = '{w.dst_addr[31:16], w.dst_addr[15:0], w.dst_port};
                        n = '{laddr[31:16], laddr[15:0], lport};
                        r.new_dst_addr = laddr;
                        r.new_dst_port = lport;
                        cnt = 3;
                    end
                    if (w.protocol == PROTO_UDP && w.l4_checksum == 0) begin
                        r.new_l4_checksum = '0;
                    end else begin
                        r.new_l4_checksum = adjust(w.l4_checksum, o, n, cnt);
                        if (w.protocol == PROTO_UDP && r.new_l4_checksum == 0)
                            r.new_l4_checksum = MASK16;
                    end
                    if (w.protocol == PROTO_ICMP) begin
                        if (w.direction) r.new_dst_addr = laddr;
                        else r.new_src_addr = gaddr;
                    end
                end
            end
            r.new_ip_checksum = header_sum(w, r.new_src_addr, r.new_dst_addr);
            pending.push_back(r);
        endfunction

        function void check_result(out_word_t got);
            out_word_t x;
            if (pending.size() == 0) begin
                $error("result word with nothing expected");
                mismatches++;
                return;
            end
            x = pending.pop_front();
            checked++;
            if (got.status !== x.status) begin
                $error("status exp %0d got %0d", x.status, got.status); mismatches++;
            end
            if (got.new_src_addr !== x.new_src_addr) begin
                $error("new_src_addr exp %h got %h", x.new_src_addr, got.new_src_addr);
                mismatches++;
            end
            if (got.new_dst_addr !== x.new_dst_addr) begin
                $error("new_dst_addr exp %h got %h", x.new_dst_addr, got.new_dst_addr);
                mismatches++;
            end
            if (got.new_src_port !== x.new_src_port) begin
                $error("new_src_port exp %h got %h", x.new_src_port, got.new_src_port);
                mismatches++;
            end
            if (got.new_dst_port !== x.new_dst_port) begin
                $error("new_dst_port exp %h got %h", x.new_dst_port, got.new_dst_port);
                mismatches++;
            end
            if (got.new_l4_checksum !== x.new_l4_checksum) begin
                $error("new_l4_checksum exp %h got %h", x.new_l4_checksum,
                       got.new_l4_checksum);
                mismatches++;
            end
            if (got.new_ip_checksum !== x.new_ip_checksum) begin
                $error("new_ip_checksum exp %h got %h", x.new_ip_checksum,
                       got.new_ip_checksum);
                mismatches++;
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_stall;
    in_word_t    in_word;
    logic        out_valid;
    logic        out_stall;
    out_word_t   out_word;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    napt_scoreboard sb;
    int  quiet_cycles;
    bit  steady;
    int  sent;
    logic [31:0] hosts[8];
    logic [15:0] lports[8];

    napt_translate_engine_core dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_stall(in_stall), .in_word(in_word),
        .out_valid(out_valid), .out_stall(out_stall), .out_word(out_word),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    initial
    begin
        clk = 0;
        forever #4 clk = ~clk;
    end

    // result check and watchdog at the rising edge
    always @(posedge clk)
    begin
        if (rst_n) begin
            if (out_valid && !out_stall) sb.check_result(out_word);
            if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
            else quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles > QUIET_LIMIT) begin
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    // receiver stalls at random
    always @(negedge clk)
    begin
        out_stall <= steady ? 1'b0 : ($urandom_range(99) < 26);
    end

    task automatic write_reg(input logic idx, input logic [31:0] val);
        @(negedge clk);
        psel <= 1; pwrite <= 1; penable <= 0; paddr <= {idx, 2'b00}; pwdata <= val;
        @(negedge clk);
        penable <= 1;
        @(negedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
        if (idx == REG_OUTSIDE_ADDR) sb.wan_addr = val;
        else sb.port_base = val[15:0];
    endtask

    // valid stays high into the next word unless an idle cycle comes between
    task automatic send_word(input in_word_t w);
        while (!steady && $urandom_range(99) < 26) begin
            in_valid <= 0;
            @(negedge clk);
        end
        in_valid <= 1;
        in_word <= w;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_packet(w);
        sent++;
        @(negedge clk);
    endtask

    task automatic drain();
        in_valid <= 0;
        while (sb.pending.size() != 0) @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    function automatic in_word_t rand_word();
        in_word_t w;
        logic [223:0] bits;
        bits = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        w = bits[$bits(in_word_t)-1:0];
        w.protocol = 2'($urandom_range(3));
        return w;
    endfunction

    // well-formed packet: outgoing from a known host or incoming to one of the low twelve table slots
    function automatic in_word_t flow_word();
        in_word_t w;
        int h;
        int k;
        w = rand_word();
        h = $urandom_range(7);
        w.protocol = 2'($urandom_range(2));
        w.icmp_type = $urandom_range(1) ? ICMP_ECHO_REQUEST : ICMP_ECHO_REPLY;
        if ($urandom_range(1)) begin
            w.direction = 0;
            w.src_ip = hosts[h];
            w.src_ident = lports[h];
        end else begin
            w.direction = 1;
            k = $urandom_range(11);
            w.dst_addr = sb.wan_addr;
            if ($urandom_range(9) == 0) w.dst_addr = $urandom;
            if (w.protocol == PROTO_ICMP) w.src_ident = 16'(k);
            else w.dst_port = 16'(sb.port_base + k);
        end
        return w;
    endfunction

    initial
    begin
        in_word_t w;
        sb = new();
        sb.clear();
        rst_n = 0; in_valid = 0; in_word = '0; out_stall = 0; steady = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        quiet_cycles = 0; sent = 0;
        foreach (hosts[i]) begin
            hosts[i] = $urandom;
            lports[i] = 16'($urandom);
        end
        repeat (12) @(negedge clk);
        rst_n = 1;

        // directed: extremes, each protocol, special cases
        write_reg(REG_OUTSIDE_ADDR, 32'hc0a80001);
        w = '0; w.protocol = PROTO_TCP; send_word(w);
        w = '1; w.protocol = PROTO_TCP; w.direction = 0; send_word(w);
        w.direction = 1; w.dst_addr = 32'hc0a80001; w.dst_port = 16'd20001; send_word(w);
        w.dst_port = 16'd20000; send_word(w);
        w.dst_port = 16'd19999; send_word(w);
        w.dst_addr = 32'h0; w.dst_port = 16'd20001; send_word(w);
        w = rand_word(); w.protocol = PROTO_UDP; w.direction = 0; w.l4_checksum = 0;
        send_word(w);
        w.l4_checksum = 16'h1234; send_word(w);
        w.direction = 1; w.dst_addr = 32'hc0a80001; w.dst_port = 16'd20000;
        w.l4_checksum = 0; send_word(w);
        w = rand_word(); w.protocol = PROTO_ICMP; w.icmp_type = ICMP_ECHO_REQUEST;
        w.direction = 0; send_word(w);
        w.direction = 1; w.dst_addr = 32'hc0a80001; w.src_ident = 0; send_word(w);
        w.icmp_type = ICMP_ECHO_REPLY; send_word(w);
        w.icmp_type = 8'd3; send_word(w);
        w.icmp_type = 8'hff; send_word(w);
        w.src_ident = 16'hffff; w.icmp_type = ICMP_ECHO_REPLY; send_word(w);
        w.protocol = PROTO_NONE; send_word(w);
        drain();
        // old entry keeps its own global address after the outside address changes
        write_reg(REG_OUTSIDE_ADDR, 32'hffffffff);
        write_reg(REG_GLOBAL_PORT_BASE, 32'd64512);
        w = '1; w.protocol = PROTO_TCP; w.direction = 0; send_word(w);
        w.direction = 1; w.dst_port = 16'd64512; w.dst_addr = 32'hc0a80001; send_word(w);
        w.dst_port = 16'd64513; w.dst_addr = 32'hffffffff; send_word(w);
        drain();

        // random phases with several register settings
        for (int ph = 0; ph < 4; ph++) begin
            write_reg(REG_OUTSIDE_ADDR, ph == 0 ? 32'h0 : $urandom);
            write_reg(REG_GLOBAL_PORT_BASE, ph == 0 ? 32'd1024 : $urandom_range(64512, 1024));
            for (int i = 0; i < 68; i++) begin
                steady = (ph == 2 && i >= 20 && i < 50);
                send_word($urandom_range(99) < 75 ? flow_word() : rand_word());
            end
            steady = 0;
            drain();
        end

        $display("ran %0d packets, %0d results checked over tcp, udp and icmp flows,",
                 sent, sb.checked);
        $display("with four register settings and random stalls on both sides");
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end
endmodule
